FILE: sv/wfn_pkg.sv
// ----------------------------------------------------------------------------
// wfn_pkg
// Shared types and constants for the wall-following navigation controller:
// state and motion codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package wfn_pkg;

    // navigation states
    typedef enum logic [2:0] {
        ST_SEARCH  = 3'd0,
        ST_HUG     = 3'd1,
        ST_CRIGHT  = 3'd2,
        ST_CLEFT   = 3'd3,
        ST_TRIGHT  = 3'd4,
        ST_TLEFT   = 3'd5,
        ST_REVERSE = 3'd6,
        ST_UNJAM   = 3'd7
    } nav_state_t;

    // motion commands
    typedef enum logic [2:0] {
        MOT_FORWARD  = 3'd0,
        MOT_RFR_SEQ  = 3'd1,
        MOT_TURN_L   = 3'd2,
        MOT_UNJAM    = 3'd3,
        MOT_BACKWARD = 3'd4
    } motion_t;

    // widths fixed by the field definitions
    localparam int unsigned FIELD_WIDTH = 16;
    localparam int unsigned TRIM_WIDTH  = 9;
    localparam int unsigned BYTE_WIDTH  = 8;
    localparam int unsigned INDEX_WIDTH = 3;

    // register indexes
    localparam logic [INDEX_WIDTH-1:0] REG_FRONT_CLOSE = 3'd0;
    localparam logic [INDEX_WIDTH-1:0] REG_FRONT_FAR   = 3'd1;
    localparam logic [INDEX_WIDTH-1:0] REG_RIGHT_CLOSE = 3'd2;
    localparam logic [INDEX_WIDTH-1:0] REG_RIGHT_FAR   = 3'd3;
    localparam logic [INDEX_WIDTH-1:0] REG_RIGHT_CORN  = 3'd4;
    localparam logic [INDEX_WIDTH-1:0] REG_JAM         = 3'd5;
    localparam logic [INDEX_WIDTH-1:0] REG_CURVE_TRIM  = 3'd6;
    localparam logic [INDEX_WIDTH-1:0] REG_STALE_LIMIT = 3'd7;

    // register reset values
    localparam logic [FIELD_WIDTH-1:0] RST_FRONT_CLOSE = 16'd50;
    localparam logic [FIELD_WIDTH-1:0] RST_FRONT_FAR   = 16'd100;
    localparam logic [FIELD_WIDTH-1:0] RST_RIGHT_CLOSE = 16'd50;
    localparam logic [FIELD_WIDTH-1:0] RST_RIGHT_FAR   = 16'd100;
    localparam logic [FIELD_WIDTH-1:0] RST_RIGHT_CORN  = 16'd300;
    localparam logic [FIELD_WIDTH-1:0] RST_JAM         = 16'd30;
    localparam logic [BYTE_WIDTH-1:0]  RST_CURVE_TRIM  = 8'd10;
    localparam logic [BYTE_WIDTH-1:0]  RST_STALE_LIMIT = 8'd10;

    // hold counter top and wall-hug delta threshold
    localparam logic [BYTE_WIDTH-1:0]         HOLD_MAX    = 8'd255;
    localparam logic signed [FIELD_WIDTH-1:0] DELTA_LIMIT = -16'sd10;

endpackage

FILE: sv/wfn_step.sv
// ----------------------------------------------------------------------------
// wfn_step
// Combinational transition and output logic: picks the next navigation
// state from the current state, hold count and readings, then derives the
// motion command and steering trim of that new state.
// ----------------------------------------------------------------------------
module wfn_step #(
    parameter int unsigned DIST_WIDTH = 16
) (
    input  wfn_pkg::nav_state_t                     cur_state,
    input  logic [wfn_pkg::BYTE_WIDTH-1:0]          hold_count,
    input  logic [DIST_WIDTH-1:0]                   front_dist,
    input  logic [DIST_WIDTH-1:0]                   right_dist,
    input  logic signed [wfn_pkg::FIELD_WIDTH-1:0]  delta_right,
    input  logic [DIST_WIDTH-1:0]                   front_close,
    input  logic [DIST_WIDTH-1:0]                   front_far,
    input  logic [DIST_WIDTH-1:0]                   right_close,
    input  logic [DIST_WIDTH-1:0]                   right_far,
    input  logic [DIST_WIDTH-1:0]                   right_corner,
    input  logic [DIST_WIDTH-1:0]                   jam_dist,
    input  logic [wfn_pkg::BYTE_WIDTH-1:0]          curve_trim,
    input  logic [wfn_pkg::BYTE_WIDTH-1:0]          stale_limit,
    output wfn_pkg::nav_state_t                     nxt_state,
    output wfn_pkg::motion_t                        motion,
    output logic signed [wfn_pkg::TRIM_WIDTH-1:0]   trim
);
    import wfn_pkg::*;

    logic jammed;
    logic f_lt_fc;
    logic f_lt_ff;
    logic r_lt_rf;
    logic signed [TRIM_WIDTH-1:0] full_trim;
    logic signed [TRIM_WIDTH-1:0] half_trim;

    // shared threshold tests
    assign jammed  = (right_dist < jam_dist) || (front_dist < jam_dist);
    assign f_lt_fc = front_dist < front_close;
    assign f_lt_ff = front_dist < front_far;
    assign r_lt_rf = right_dist < right_far;

    // next state, highest priority rule first
    always_comb begin
        nxt_state = cur_state;
        case (cur_state)
            ST_SEARCH: begin
                if (f_lt_fc)      nxt_state = ST_REVERSE;
                else if (f_lt_ff) nxt_state = ST_TLEFT;
                else if (r_lt_rf) nxt_state = ST_HUG;
            end
            ST_HUG: begin
                if (jammed)                         nxt_state = ST_UNJAM;
                else if (f_lt_fc)                   nxt_state = ST_REVERSE;
                else if (f_lt_ff)                   nxt_state = ST_TLEFT;
                else if (right_dist > right_corner) nxt_state = ST_TRIGHT;
                else if (right_dist > right_far)    nxt_state = ST_CRIGHT;
                else if (right_dist < right_close)  nxt_state = ST_CLEFT;
            end
            ST_CRIGHT: begin
                if (jammed)                        nxt_state = ST_UNJAM;
                else if (f_lt_fc)                  nxt_state = ST_REVERSE;
                else if (f_lt_ff)                  nxt_state = ST_TLEFT;
                else if (right_dist > right_close) nxt_state = ST_HUG;
            end
            ST_CLEFT: begin
                if (jammed)       nxt_state = ST_UNJAM;
                else if (f_lt_fc) nxt_state = ST_REVERSE;
                else if (f_lt_ff) nxt_state = ST_TLEFT;
                else if (r_lt_rf) nxt_state = ST_HUG;
            end
            ST_TRIGHT: begin
                // give up after too long in the turn
                if (hold_count > stale_limit) nxt_state = ST_SEARCH;
                else if (f_lt_fc)             nxt_state = ST_REVERSE;
                else if (f_lt_ff)             nxt_state = ST_TLEFT;
                else if (r_lt_rf)             nxt_state = ST_HUG;
            end
            ST_TLEFT: begin
                if (jammed)       nxt_state = ST_UNJAM;
                else if (f_lt_fc) nxt_state = ST_REVERSE;
                else if ((front_dist > front_far) && (right_dist < right_corner))
                    nxt_state = ST_SEARCH;
            end
            ST_UNJAM: begin
                if ((right_dist > jam_dist) && (front_dist > jam_dist))
                    nxt_state = ST_SEARCH;
            end
            ST_REVERSE: begin
                if (front_dist > front_close) nxt_state = ST_TLEFT;
            end
            default: nxt_state = cur_state;
        endcase
    end

    // trim magnitudes, full and truncated half
    assign full_trim = $signed({1'b0, curve_trim});
    assign half_trim = $signed({2'b00, curve_trim[BYTE_WIDTH-1:1]});

    // motion command and trim of the new state
    always_comb begin
        motion = MOT_FORWARD;
        trim   = '0;
        case (nxt_state)
            ST_HUG: begin
                trim = (delta_right > DELTA_LIMIT) ? half_trim : -half_trim;
            end
            ST_CRIGHT:  trim   = -full_trim;
            ST_CLEFT:   trim   = full_trim;
            ST_TRIGHT:  motion = MOT_RFR_SEQ;
            ST_TLEFT:   motion = MOT_TURN_L;
            ST_UNJAM:   motion = MOT_UNJAM;
            ST_REVERSE: motion = MOT_BACKWARD;
            default:    motion = MOT_FORWARD;
        endcase
    end

endmodule

FILE: sv/wall_follow_nav_fsm_unit.sv
// ----------------------------------------------------------------------------
// wall_follow_nav_fsm_unit
// Eight-state wall-following navigation controller with a plain
// configuration write port and valid/ready reading and command channels.
// ----------------------------------------------------------------------------
// One item per clock: a reading is taken whenever the result register is
// empty or its item is being taken in the same cycle, and its command
// appears in the result register in the cycle after acceptance. The whole
// decision (hold count update, threshold tests, next state, motion and
// trim) is a single level of logic between the accepted reading and the
// result register, so the state that the next item sees is already updated
// at that edge. Distances and distance thresholds are compared on their low
// DIST_WIDTH bits. After reset the block is in the searching state with a
// hold count of zero and all thresholds at their defaults.
module wall_follow_nav_fsm_unit #(
    parameter int unsigned DIST_WIDTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration writes
    input  logic                                    cfg_wr_en,
    input  logic [wfn_pkg::INDEX_WIDTH-1:0]         cfg_addr,
    input  logic [wfn_pkg::FIELD_WIDTH-1:0]         cfg_wr_data,
    // readings
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [wfn_pkg::FIELD_WIDTH-1:0]         s_front_dist,
    input  logic [wfn_pkg::FIELD_WIDTH-1:0]         s_right_dist,
    input  logic signed [wfn_pkg::FIELD_WIDTH-1:0]  s_delta_right,
    // commands
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [2:0]                              m_new_state,
    output logic [2:0]                              m_motion,
    output logic signed [wfn_pkg::TRIM_WIDTH-1:0]   m_trim
);
    import wfn_pkg::*;

    // threshold registers
    logic [DIST_WIDTH-1:0] front_close_reg;
    logic [DIST_WIDTH-1:0] front_far_reg;
    logic [DIST_WIDTH-1:0] right_close_reg;
    logic [DIST_WIDTH-1:0] right_far_reg;
    logic [DIST_WIDTH-1:0] right_corner_reg;
    logic [DIST_WIDTH-1:0] jam_dist_reg;
    logic [BYTE_WIDTH-1:0] curve_trim_reg;
    logic [BYTE_WIDTH-1:0] stale_limit_reg;

    // controller state
    nav_state_t            nav_state_reg;
    nav_state_t            prev_state_reg;
    logic [BYTE_WIDTH-1:0] hold_count_reg;
    logic [BYTE_WIDTH-1:0] hold_count_next;

    // result register
    logic                         m_valid_reg;
    logic [2:0]                   new_state_reg;
    logic [2:0]                   motion_reg;
    logic signed [TRIM_WIDTH-1:0] trim_reg;

    logic                         accept;
    nav_state_t                   step_state;
    motion_t                      step_motion;
    logic signed [TRIM_WIDTH-1:0] step_trim;

    // handshake
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_close_reg  <= RST_FRONT_CLOSE[DIST_WIDTH-1:0];
            front_far_reg    <= RST_FRONT_FAR[DIST_WIDTH-1:0];
            right_close_reg  <= RST_RIGHT_CLOSE[DIST_WIDTH-1:0];
            right_far_reg    <= RST_RIGHT_FAR[DIST_WIDTH-1:0];
            right_corner_reg <= RST_RIGHT_CORN[DIST_WIDTH-1:0];
            jam_dist_reg     <= RST_JAM[DIST_WIDTH-1:0];
            curve_trim_reg   <= RST_CURVE_TRIM;
            stale_limit_reg  <= RST_STALE_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FRONT_CLOSE: front_close_reg  <= cfg_wr_data[DIST_WIDTH-1:0];
                REG_FRONT_FAR:   front_far_reg    <= cfg_wr_data[DIST_WIDTH-1:0];
                REG_RIGHT_CLOSE: right_close_reg  <= cfg_wr_data[DIST_WIDTH-1:0];
                REG_RIGHT_FAR:   right_far_reg    <= cfg_wr_data[DIST_WIDTH-1:0];
                REG_RIGHT_CORN:  right_corner_reg <= cfg_wr_data[DIST_WIDTH-1:0];
                REG_JAM:         jam_dist_reg     <= cfg_wr_data[DIST_WIDTH-1:0];
                REG_CURVE_TRIM:  curve_trim_reg   <= cfg_wr_data[BYTE_WIDTH-1:0];
                REG_STALE_LIMIT: stale_limit_reg  <= cfg_wr_data[BYTE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // hold counter: counts steps spent in one state, saturating
    always_comb begin
        if (nav_state_reg == prev_state_reg) begin
            hold_count_next = (hold_count_reg == HOLD_MAX) ? hold_count_reg
                                                           : hold_count_reg + 8'd1;
        end else begin
            hold_count_next = '0;
        end
    end

    // transition and command logic
    wfn_step #(
        .DIST_WIDTH (DIST_WIDTH)
    ) u_step (
        .cur_state    (nav_state_reg),
        .hold_count   (hold_count_next),
        .front_dist   (s_front_dist[DIST_WIDTH-1:0]),
        .right_dist   (s_right_dist[DIST_WIDTH-1:0]),
        .delta_right  (s_delta_right),
        .front_close  (front_close_reg),
        .front_far    (front_far_reg),
        .right_close  (right_close_reg),
        .right_far    (right_far_reg),
        .right_corner (right_corner_reg),
        .jam_dist     (jam_dist_reg),
        .curve_trim   (curve_trim_reg),
        .stale_limit  (stale_limit_reg),
        .nxt_state    (step_state),
        .motion       (step_motion),
        .trim         (step_trim)
    );

    // state update on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nav_state_reg  <= ST_SEARCH;
            prev_state_reg <= ST_SEARCH;
            hold_count_reg <= '0;
        end else if (accept) begin
            nav_state_reg  <= step_state;
            prev_state_reg <= nav_state_reg;
            hold_count_reg <= hold_count_next;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            new_state_reg <= step_state;
            motion_reg    <= step_motion;
            trim_reg      <= step_trim;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_state = new_state_reg;
    assign m_motion    = motion_reg;
    assign m_trim      = trim_reg;

endmodule

FILE: tb/wall_follow_nav_fsm_unit_test.sv
// ----------------------------------------------------------------------------
// wall_follow_nav_fsm_unit_test
// Self-checking bench for the wall-following navigation controller.
// Readings are offered in bursts over valid/ready while the command side
// stalls on its own pattern. Every command is compared field by field with a
// local model of the state machine, the hold counter and the steering trim.
// A short directed walk through the states comes first, then random readings
// under several threshold settings: defaults, all-zero, all-ones and random.
// ----------------------------------------------------------------------------
module wall_follow_nav_fsm_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wfn_pkg::*;

    localparam int unsigned DIST_BITS   = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PRINT_LIMIT = 40;
    localparam int unsigned LONG_STALL  = 400;
    localparam logic [FIELD_WIDTH-1:0] DIST_MASK =
        FIELD_WIDTH'((32'd1 << DIST_BITS) - 32'd1);

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] front;
        logic [FIELD_WIDTH-1:0] right;
        logic [FIELD_WIDTH-1:0] delta;
    } reading_t;

    typedef struct packed {
        nav_state_t            nav;
        motion_t               motion;
        logic [TRIM_WIDTH-1:0] trim;
    } command_t;

    typedef struct packed {
        reading_t    rd;
        int unsigned reps;
        logic        fixed;
        command_t    cmd;
    } walk_row_t;

    // directed walk from reset, default thresholds
    localparam walk_row_t WALK_PLAN [19] = '{
        // search, front at zero: reverse
        '{'{16'd0, 16'hFFFF, 16'd0}, 1, 1'b1, '{ST_REVERSE, MOT_BACKWARD, 9'd0}},
        // reverse, front clear: turn left
        '{'{16'hFFFF, 16'hFFFF, 16'd0}, 1, 1'b1, '{ST_TLEFT, MOT_TURN_L, 9'd0}},
        // turn left, right at zero: jammed
        '{'{16'hFFFF, 16'd0, 16'd0}, 1, 1'b1, '{ST_UNJAM, MOT_UNJAM, 9'd0}},
        // unjam needs both sides strictly above the jam distance
        '{'{16'hFFFF, 16'd30, 16'd0}, 1, 1'b1, '{ST_UNJAM, MOT_UNJAM, 9'd0}},
        '{'{16'hFFFF, 16'd31, 16'd0}, 1, 1'b1, '{ST_SEARCH, MOT_FORWARD, 9'd0}},
        // wall found, trim sign follows delta around -10
        '{'{16'hFFFF, 16'd60, 16'h7FFF}, 1, 1'b1, '{ST_HUG, MOT_FORWARD, 9'd5}},
        '{'{16'hFFFF, 16'd60, 16'hFFF6}, 1, 1'b1, '{ST_HUG, MOT_FORWARD, 9'h1FB}},
        '{'{16'hFFFF, 16'd60, 16'hFFF7}, 1, 1'b1, '{ST_HUG, MOT_FORWARD, 9'd5}},
        '{'{16'hFFFF, 16'd60, 16'h8000}, 1, 1'b1, '{ST_HUG, MOT_FORWARD, 9'h1FB}},
        // drifting off the wall, then back
        '{'{16'hFFFF, 16'd200, 16'd0}, 1, 1'b1, '{ST_CRIGHT, MOT_FORWARD, 9'h1F6}},
        '{'{16'hFFFF, 16'd50, 16'd0}, 1, 1'b1, '{ST_CRIGHT, MOT_FORWARD, 9'h1F6}},
        '{'{16'hFFFF, 16'd51, 16'd0}, 1, 1'b1, '{ST_HUG, MOT_FORWARD, 9'd5}},
        '{'{16'hFFFF, 16'd49, 16'd0}, 1, 1'b1, '{ST_CLEFT, MOT_FORWARD, 9'd10}},
        '{'{16'hFFFF, 16'd99, 16'd0}, 1, 1'b1, '{ST_HUG, MOT_FORWARD, 9'd5}},
        // outside corner
        '{'{16'hFFFF, 16'd301, 16'd0}, 1, 1'b1, '{ST_TRIGHT, MOT_RFR_SEQ, 9'd0}},
        // turn right held until the hold count passes the stale limit
        '{'{16'hFFFF, 16'hFFFF, 16'd0}, 12, 1'b0, '{ST_SEARCH, MOT_FORWARD, 9'd0}},
        '{'{16'hFFFF, 16'd60, 16'd0}, 1, 1'b0, '{ST_SEARCH, MOT_FORWARD, 9'd0}},
        '{'{16'd99, 16'd60, 16'd0}, 1, 1'b0, '{ST_SEARCH, MOT_FORWARD, 9'd0}},
        '{'{16'd101, 16'd60, 16'd0}, 1, 1'b0, '{ST_SEARCH, MOT_FORWARD, 9'd0}}
    };

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   cfg_wr_en     = 1'b0;
    logic [INDEX_WIDTH-1:0] cfg_addr      = '0;
    logic [FIELD_WIDTH-1:0] cfg_wr_data   = '0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [FIELD_WIDTH-1:0] s_front_dist  = '0;
    logic [FIELD_WIDTH-1:0] s_right_dist  = '0;
    logic [FIELD_WIDTH-1:0] s_delta_right = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic [2:0]             m_new_state;
    logic [2:0]             m_motion;
    logic [TRIM_WIDTH-1:0]  m_trim;

    // local copy of the controller state and thresholds
    nav_state_t             model_nav;
    nav_state_t             model_prev;
    logic [BYTE_WIDTH-1:0]  model_hold;
    logic [FIELD_WIDTH-1:0] thresholds [8];
    logic [FIELD_WIDTH-1:0] cfg_plan [8];

    command_t    expected_cmds [$];
    int unsigned mismatch_count = 0;
    int unsigned commands_seen  = 0;
    int unsigned readings_sent  = 0;
    int unsigned settings_used  = 0;
    logic [7:0]  states_reached = '0;
    logic        offer_open     = 1'b0;
    int unsigned burst_left     = 1;

    wall_follow_nav_fsm_unit #(
        .DIST_WIDTH(DIST_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_front_dist (s_front_dist),
        .s_right_dist (s_right_dist),
        .s_delta_right(s_delta_right),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_state  (m_new_state),
        .m_motion     (m_motion),
        .m_trim       (m_trim)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // next state from the current state and the masked readings
    function automatic nav_state_t next_nav(nav_state_t cur, logic [FIELD_WIDTH-1:0] f,
                                            logic [FIELD_WIDTH-1:0] r);
        logic [FIELD_WIDTH-1:0] fc;
        logic [FIELD_WIDTH-1:0] ff;
        logic [FIELD_WIDTH-1:0] rc;
        logic [FIELD_WIDTH-1:0] rf;
        logic [FIELD_WIDTH-1:0] rk;
        logic [FIELD_WIDTH-1:0] jm;
        logic                   jammed;
        fc = thresholds[REG_FRONT_CLOSE] & DIST_MASK;
        ff = thresholds[REG_FRONT_FAR] & DIST_MASK;
        rc = thresholds[REG_RIGHT_CLOSE] & DIST_MASK;
        rf = thresholds[REG_RIGHT_FAR] & DIST_MASK;
        rk = thresholds[REG_RIGHT_CORN] & DIST_MASK;
        jm = thresholds[REG_JAM] & DIST_MASK;
        jammed = (r < jm) || (f < jm);
        case (cur)
            ST_SEARCH: begin
                if (f < fc) return ST_REVERSE;
                if (f < ff) return ST_TLEFT;
                if (r < rf) return ST_HUG;
            end
            ST_HUG: begin
                if (jammed) return ST_UNJAM;
                if (f < fc) return ST_REVERSE;
                if (f < ff) return ST_TLEFT;
                if (r > rk) return ST_TRIGHT;
                if (r > rf) return ST_CRIGHT;
                if (r < rc) return ST_CLEFT;
            end
            ST_CRIGHT: begin
                if (jammed) return ST_UNJAM;
                if (f < fc) return ST_REVERSE;
                if (f < ff) return ST_TLEFT;
                if (r > rc) return ST_HUG;
            end
            ST_CLEFT: begin
                if (jammed) return ST_UNJAM;
                if (f < fc) return ST_REVERSE;
                if (f < ff) return ST_TLEFT;
                if (r < rf) return ST_HUG;
            end
            ST_TRIGHT: begin
                if (model_hold > thresholds[REG_STALE_LIMIT][BYTE_WIDTH-1:0]) return ST_SEARCH;
                if (f < fc) return ST_REVERSE;
                if (f < ff) return ST_TLEFT;
                if (r < rf) return ST_HUG;
            end
            ST_TLEFT: begin
                if (jammed) return ST_UNJAM;
                if (f < fc) return ST_REVERSE;
                if (f > ff && r < rk) return ST_SEARCH;
            end
            ST_UNJAM: begin
                if (r > jm && f > jm) return ST_SEARCH;
            end
            default: begin
                if (f > fc) return ST_TLEFT;
            end
        endcase
        return cur;
    endfunction

    // advance the local state by one reading and form its command
    function automatic command_t predict_command(reading_t rd);
        logic [BYTE_WIDTH-1:0]   gain;
        logic [BYTE_WIDTH-1:0]   half;
        logic signed [FIELD_WIDTH-1:0] delta;
        command_t                c;
        gain  = thresholds[REG_CURVE_TRIM][BYTE_WIDTH-1:0];
        half  = gain >> 1;
        delta = rd.delta;
        if (model_nav == model_prev) begin
            if (model_hold != HOLD_MAX) model_hold = model_hold + 8'd1;
        end else begin
            model_hold = '0;
        end
        model_prev = model_nav;
        model_nav  = next_nav(model_nav, rd.front & DIST_MASK, rd.right & DIST_MASK);
        c.nav    = model_nav;
        c.motion = MOT_FORWARD;
        c.trim   = '0;
        case (model_nav)
            ST_HUG:     c.trim = (delta > DELTA_LIMIT) ? {1'b0, half} : -{1'b0, half};
            ST_CRIGHT:  c.trim = -{1'b0, gain};
            ST_CLEFT:   c.trim = {1'b0, gain};
            ST_TRIGHT:  c.motion = MOT_RFR_SEQ;
            ST_TLEFT:   c.motion = MOT_TURN_L;
            ST_UNJAM:   c.motion = MOT_UNJAM;
            ST_REVERSE: c.motion = MOT_BACKWARD;
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] pick_distance();
        logic [FIELD_WIDTH-1:0] base;
        int unsigned            sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return '1;
            2, 3: return FIELD_WIDTH'($urandom);
            default: begin
                // land around one of the live thresholds
                base = thresholds[$urandom_range(REG_FRONT_CLOSE, REG_JAM)];
                return base + FIELD_WIDTH'($urandom_range(0, 4)) - 16'd2;
            end
        endcase
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] pick_delta();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        case (sel)
            0: return DELTA_LIMIT;
            1: return DELTA_LIMIT + 16'd1;
            2: return DELTA_LIMIT - 16'd1;
            3: return 16'h8000;
            4: return 16'h7FFF;
            default: return FIELD_WIDTH'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at command %0d: %s got %0d expected %0d",
                     commands_seen, what, got, want);
    endtask

    // offer one reading and hold it until taken; valid stays up afterwards
    task automatic send_reading(reading_t rd, logic use_fixed, command_t fixed_cmd);
        command_t predicted;
        s_valid       <= 1'b1;
        s_front_dist  <= rd.front;
        s_right_dist  <= rd.right;
        s_delta_right <= rd.delta;
        offer_open = 1'b1;
        do @(posedge aclk); while (!s_ready);
        readings_sent++;
        predicted = predict_command(rd);
        expected_cmds.push_back(use_fixed ? fixed_cmd : predicted);
    endtask

    // burst pacing on the reading side
    task automatic pace();
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            offer_open = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic close_offer();
        if (offer_open) begin
            s_valid <= 1'b0;
            offer_open = 1'b0;
        end
    endtask

    // wait until every outstanding command has come back
    task automatic wait_drained();
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // write all eight registers from cfg_plan, one per clock
    task automatic program_thresholds();
        for (int i = 0; i <= REG_STALE_LIMIT; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= INDEX_WIDTH'(i);
            cfg_wr_data <= cfg_plan[i];
            @(posedge aclk);
            thresholds[i] = (i >= REG_CURVE_TRIM) ? (cfg_plan[i] & 16'h00FF) : cfg_plan[i];
        end
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic plan_defaults();
        cfg_plan[REG_FRONT_CLOSE] = RST_FRONT_CLOSE;
        cfg_plan[REG_FRONT_FAR]   = RST_FRONT_FAR;
        cfg_plan[REG_RIGHT_CLOSE] = RST_RIGHT_CLOSE;
        cfg_plan[REG_RIGHT_FAR]   = RST_RIGHT_FAR;
        cfg_plan[REG_RIGHT_CORN]  = RST_RIGHT_CORN;
        cfg_plan[REG_JAM]         = RST_JAM;
        cfg_plan[REG_CURVE_TRIM]  = {BYTE_WIDTH'($urandom), RST_CURVE_TRIM};
        cfg_plan[REG_STALE_LIMIT] = {BYTE_WIDTH'($urandom), RST_STALE_LIMIT};
    endtask

    // mostly small thresholds so the states stay reachable
    task automatic plan_random(logic stale_zero);
        for (int i = 0; i <= REG_JAM; i++)
            cfg_plan[i] = ($urandom_range(0, 3) != 0) ? FIELD_WIDTH'($urandom_range(0, 400))
                                                      : FIELD_WIDTH'($urandom);
        cfg_plan[REG_CURVE_TRIM]  = FIELD_WIDTH'($urandom);
        cfg_plan[REG_STALE_LIMIT] = {BYTE_WIDTH'($urandom),
                                     stale_zero ? 8'd0 : BYTE_WIDTH'($urandom_range(0, 30))};
    endtask

    task automatic random_readings(int unsigned count, logic pause_midway);
        reading_t    rd;
        int unsigned sent;
        int unsigned run;
        logic        paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < count) begin
            rd.front = pick_distance();
            rd.right = pick_distance();
            rd.delta = pick_delta();
            // now and then the same reading repeats to let the hold count build
            run = ($urandom_range(0, 99) < 8) ? $urandom_range(3, 40) : 1;
            repeat (run) begin
                send_reading(rd, 1'b0, '0);
                pace();
                sent++;
            end
            if (pause_midway && !paused && sent >= count / 2) begin
                close_offer();
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    // lead onto the wall, then sit in turn right long enough to saturate
    task automatic corner_run();
        repeat (4) begin
            send_reading('{16'hFFFF, 16'd60, 16'd0}, 1'b0, '0);
            pace();
        end
        repeat (300) begin
            send_reading('{16'hFFFF, 16'hFFFF, 16'd0}, 1'b0, '0);
            pace();
        end
    endtask

    // stimulus and end of run
    initial begin
        model_nav  = ST_SEARCH;
        model_prev = ST_SEARCH;
        model_hold = '0;
        plan_defaults();
        for (int i = 0; i <= REG_STALE_LIMIT; i++)
            thresholds[i] = (i >= REG_CURVE_TRIM) ? (cfg_plan[i] & 16'h00FF) : cfg_plan[i];
        settings_used = 1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed walk
        for (int i = 0; i < $size(WALK_PLAN); i++) begin
            repeat (WALK_PLAN[i].reps) begin
                send_reading(WALK_PLAN[i].rd, WALK_PLAN[i].fixed, WALK_PLAN[i].cmd);
                pace();
            end
        end
        random_readings(230, 1'b0);
        close_offer();
        wait_drained();

        // every threshold at zero: below tests never fire
        for (int i = 0; i <= REG_STALE_LIMIT; i++) cfg_plan[i] = '0;
        program_thresholds();
        random_readings(100, 1'b0);
        close_offer();
        wait_drained();

        // every threshold at its top
        for (int i = 0; i <= REG_STALE_LIMIT; i++) cfg_plan[i] = '1;
        program_thresholds();
        random_readings(150, 1'b0);
        close_offer();
        wait_drained();

        // defaults with a stale limit that never fires
        plan_defaults();
        cfg_plan[REG_STALE_LIMIT][BYTE_WIDTH-1:0] = HOLD_MAX;
        program_thresholds();
        corner_run();
        random_readings(100, 1'b0);
        close_offer();
        wait_drained();

        // random settings, one with a zero stale limit
        for (int p = 0; p < 3; p++) begin
            plan_random(p == 0);
            program_thresholds();
            random_readings(300, p == 1);
            close_offer();
            wait_drained();
        end

        repeat (5) @(posedge aclk);
        $display("%0d readings under %0d threshold settings, %0d commands checked",
                 readings_sent, settings_used, commands_seen);
        $display("states reached %08b, %0d mismatches", states_reached, mismatch_count);
        if (mismatch_count == 0 && expected_cmds.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // command side readiness: changing patterns plus one long hold-off
    initial begin : command_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned stall_left;
        logic        long_done;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        long_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (!long_done && commands_seen >= 600) begin
                stall_left = LONG_STALL;
                long_done  = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // compare each command taken with the oldest expectation
    always @(posedge aclk) begin : command_check
        command_t want;
        if (aresetn && m_valid && m_ready) begin
            commands_seen++;
            states_reached[m_new_state] = 1'b1;
            if (expected_cmds.size() == 0) begin
                report_mismatch("unexpected command, new_state", m_new_state, 0);
            end else begin
                want = expected_cmds.pop_front();
                if (m_new_state !== want.nav)
                    report_mismatch("new_state", m_new_state, want.nav);
                if (m_motion !== want.motion)
                    report_mismatch("motion", m_motion, want.motion);
                if (m_trim !== want.trim)
                    report_mismatch("trim", $signed(m_trim), $signed(want.trim));
            end
        end
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/wfn_pkg.sv
sv/wfn_step.sv
sv/wall_follow_nav_fsm_unit.sv
tb/wall_follow_nav_fsm_unit_test.sv
